FILE: src/idpst_pkg.sv
// ----------------------------------------------------------------------------
// idpst_pkg
// Shared constants, operation and status codes, and memory request types for
// the identifier pool with signature table.
// ----------------------------------------------------------------------------
package idpst_pkg;

  localparam int POOL_SIZE = 1024;
  localparam int SIG_BITS  = 32;
  localparam int POOL_AW   = $clog2(POOL_SIZE);
  localparam int CNT_W     = $clog2(POOL_SIZE + 1);

  localparam int OP_W     = 3;
  localparam int IDENT_W  = 10;
  localparam int SIG_IO_W = 32;
  localparam int LIVE_W   = 11;
  localparam int STAT_W   = 2;

  localparam int IN_DATA_W    = ((IDENT_W + SIG_IO_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = ((IDENT_W + SIG_IO_W + LIVE_W + 7) / 8) * 8;
  localparam int OUT_SIG_LSB  = IDENT_W;
  localparam int OUT_LIVE_LSB = IDENT_W + SIG_IO_W;

  localparam logic [OP_W-1:0] OP_CREATE      = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY     = 3'd1;
  localparam logic [OP_W-1:0] OP_GET         = 3'd2;
  localparam logic [OP_W-1:0] OP_SET         = 3'd3;
  localparam logic [OP_W-1:0] OP_DESTROY_ALL = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic               rd_en;
    logic [POOL_AW-1:0] rd_addr;
    logic               wr_en;
    logic [POOL_AW-1:0] wr_addr;
    logic [POOL_AW-1:0] wr_data;
  } ring_req_t;

  typedef struct packed {
    logic                rd_en;
    logic [POOL_AW-1:0]  rd_addr;
    logic                wr_en;
    logic [POOL_AW-1:0]  wr_addr;
    logic [SIG_BITS-1:0] wr_data;
  } sig_req_t;

endpackage

FILE: src/idpst_free_ring.sv
// ----------------------------------------------------------------------------
// idpst_free_ring
// Free list storage: one identifier per slot, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module idpst_free_ring (
  input  logic                            clk,
  input  idpst_pkg::ring_req_t            req,
  output logic [idpst_pkg::POOL_AW-1:0]   rdata
);
  import idpst_pkg::*;

  logic [POOL_AW-1:0] mem [POOL_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

FILE: src/idpst_sig_table.sv
// ----------------------------------------------------------------------------
// idpst_sig_table
// Signature storage: one mask per identifier, one write and one registered
// read per cycle.
// ----------------------------------------------------------------------------
module idpst_sig_table (
  input  logic                             clk,
  input  idpst_pkg::sig_req_t              req,
  output logic [idpst_pkg::SIG_BITS-1:0]   rdata
);
  import idpst_pkg::*;

  logic [SIG_BITS-1:0] mem [POOL_SIZE];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_addr];
    end
  end

endmodule

FILE: src/idpst_ctrl.sv
// ----------------------------------------------------------------------------
// idpst_ctrl
// Sequencer: reads both memories on accept, modifies and writes back once
// the result register is free, holds head, tail and live count, sweeps both
// memories after reset and on destroy-all, and keeps the result register.
// ----------------------------------------------------------------------------
module idpst_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [idpst_pkg::OP_W-1:0]        in_op,
  input  logic [idpst_pkg::IDENT_W-1:0]     in_ident,
  input  logic [idpst_pkg::SIG_IO_W-1:0]    in_sig,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [idpst_pkg::IDENT_W-1:0]     out_ident,
  output logic [idpst_pkg::SIG_IO_W-1:0]    out_sig,
  output logic [idpst_pkg::LIVE_W-1:0]      out_live,
  output logic [idpst_pkg::STAT_W-1:0]      out_stat,
  output idpst_pkg::ring_req_t              ring_req,
  input  logic [idpst_pkg::POOL_AW-1:0]     ring_rdata,
  output idpst_pkg::sig_req_t               sig_req,
  input  logic [idpst_pkg::SIG_BITS-1:0]    sig_rdata
);
  import idpst_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_CLEAR = 2'd2;

  localparam logic [POOL_AW-1:0] LAST_SLOT = POOL_AW'(POOL_SIZE - 1);

  logic [1:0]          state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [IDENT_W-1:0]  ident_r;
  logic [SIG_BITS-1:0] sig_r;
  logic [POOL_AW-1:0]  head_r, head_nxt;
  logic [POOL_AW-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]    alloc_r, alloc_nxt;
  logic [POOL_AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic                clr_emit_r, clr_emit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [IDENT_W-1:0]  out_ident_r, out_ident_nxt;
  logic [SIG_IO_W-1:0] out_sig_r, out_sig_nxt;
  logic [LIVE_W-1:0]   out_live_r, out_live_nxt;
  logic [STAT_W-1:0]   out_stat_r, out_stat_nxt;

  logic               accept;
  logic               finish;
  logic               in_range;
  logic [POOL_AW-1:0] ident_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign finish    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign in_range  = 32'(ident_r) < 32'(POOL_SIZE);
  assign ident_idx = POOL_AW'(ident_r);

  assign out_valid = out_valid_r;
  assign out_ident = out_ident_r;
  assign out_sig   = out_sig_r;
  assign out_live  = out_live_r;
  assign out_stat  = out_stat_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    alloc_nxt     = alloc_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_emit_nxt  = clr_emit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ident_nxt = out_ident_r;
    out_sig_nxt   = out_sig_r;
    out_live_nxt  = out_live_r;
    out_stat_nxt  = out_stat_r;

    ring_req.rd_en   = accept;
    ring_req.rd_addr = head_r;
    ring_req.wr_en   = 1'b0;
    ring_req.wr_addr = tail_r;
    ring_req.wr_data = ident_idx;
    sig_req.rd_en    = accept;
    sig_req.rd_addr  = POOL_AW'(in_ident);
    sig_req.wr_en    = 1'b0;
    sig_req.wr_addr  = ident_idx;
    sig_req.wr_data  = sig_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_DESTROY_ALL) begin
            state_nxt    = S_CLEAR;
            clr_cnt_nxt  = '0;
            clr_emit_nxt = 1'b1;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (finish) begin
          out_ident_nxt = ident_r;
          out_sig_nxt   = '0;
          out_stat_nxt  = STAT_OK;
          unique case (op_r)
            OP_CREATE: begin
              if (alloc_r >= CNT_W'(POOL_SIZE)) begin
                out_stat_nxt = STAT_EMPTY;
              end else begin
                out_ident_nxt = IDENT_W'(ring_rdata);
                head_nxt      = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
                alloc_nxt     = alloc_r + 1'b1;
              end
            end
            OP_DESTROY: begin
              if (!in_range) begin
                out_stat_nxt = STAT_RANGE;
              end else if (alloc_r != '0) begin
                sig_req.wr_en   = 1'b1;
                sig_req.wr_data = '0;
                ring_req.wr_en  = 1'b1;
                tail_nxt        = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
                alloc_nxt       = alloc_r - 1'b1;
              end
            end
            OP_GET: begin
              if (!in_range) begin
                out_stat_nxt = STAT_RANGE;
              end else begin
                out_sig_nxt = SIG_IO_W'(sig_rdata);
              end
            end
            OP_SET: begin
              if (!in_range) begin
                out_stat_nxt = STAT_RANGE;
              end else begin
                sig_req.wr_en = 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_live_nxt  = LIVE_W'(alloc_nxt);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_CLEAR: begin
        ring_req.wr_en   = 1'b1;
        ring_req.wr_addr = clr_cnt_r;
        ring_req.wr_data = clr_cnt_r;
        sig_req.wr_en    = 1'b1;
        sig_req.wr_addr  = clr_cnt_r;
        sig_req.wr_data  = '0;
        clr_cnt_nxt      = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_SLOT) begin
          head_nxt     = '0;
          tail_nxt     = '0;
          alloc_nxt    = '0;
          clr_emit_nxt = 1'b0;
          state_nxt    = clr_emit_r ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      tail_r      <= '0;
      alloc_r     <= '0;
      clr_cnt_r   <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      alloc_r     <= alloc_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      ident_r <= in_ident;
      sig_r   <= SIG_BITS'(in_sig);
    end
    out_ident_r <= out_ident_nxt;
    out_sig_r   <= out_sig_nxt;
    out_live_r  <= out_live_nxt;
    out_stat_r  <= out_stat_nxt;
  end

endmodule

FILE: src/id_pool_with_signature_table_core.sv
// ----------------------------------------------------------------------------
// id_pool_with_signature_table_core
// Identifier allocator with a FIFO free list and a signature mask per
// identifier.
//
// The in_ channel carries one operation per transfer: create, destroy, get
// signature, set signature or destroy-all. The out_ channel returns exactly
// one result per operation: identifier, signature read, live count, status.
// Create, destroy, get and set read both memories at the accepting edge;
// once the result register is free, the controller modifies, writes back
// and loads the result. A new operation is accepted only after the
// previous one has finished; the free-list and signature memory
// read-modify-write sets this.
// Destroy-all sweeps both memories one entry a cycle, then returns its result.
// After reset the same sweep runs over all POOL_SIZE entries with in_tready
// low. A stalled receiver holds the result register; the next operation is
// still accepted, and its write-back waits until the register is taken.
// ----------------------------------------------------------------------------
module id_pool_with_signature_table_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // ident [9:0], sig_in [41:10], zero pad
  input  logic [idpst_pkg::IN_DATA_W-1:0]       in_tdata,
  // op [2:0]
  input  logic [idpst_pkg::OP_W-1:0]            in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // ident_out [9:0], sig_out [41:10], live_count [52:42], zero pad
  output logic [idpst_pkg::OUT_DATA_W-1:0]      out_tdata,
  // status [1:0]
  output logic [idpst_pkg::STAT_W-1:0]          out_tuser
);
  import idpst_pkg::*;

  ring_req_t           ring_req;
  sig_req_t            sig_req;
  logic [POOL_AW-1:0]  ring_rdata;
  logic [SIG_BITS-1:0] sig_rdata;
  logic [IDENT_W-1:0]  out_ident;
  logic [SIG_IO_W-1:0] out_sig;
  logic [LIVE_W-1:0]   out_live;

  idpst_free_ring u_ring (
    .clk   (clk),
    .req   (ring_req),
    .rdata (ring_rdata)
  );

  idpst_sig_table u_sig (
    .clk   (clk),
    .req   (sig_req),
    .rdata (sig_rdata)
  );

  idpst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tuser),
    .in_ident   (in_tdata[IDENT_W-1:0]),
    .in_sig     (in_tdata[IDENT_W +: SIG_IO_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_ident  (out_ident),
    .out_sig    (out_sig),
    .out_live   (out_live),
    .out_stat   (out_tuser),
    .ring_req   (ring_req),
    .ring_rdata (ring_rdata),
    .sig_req    (sig_req),
    .sig_rdata  (sig_rdata)
  );

  assign out_tdata = OUT_DATA_W'({out_live, out_sig, out_ident});

endmodule

FILE: src/idpst_checker.sv
// ----------------------------------------------------------------------------
// idpst_checker
// Port-level checks on the identifier pool, bound to the top level.
// ----------------------------------------------------------------------------
module idpst_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tvalid,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [idpst_pkg::OUT_DATA_W-1:0]     out_tdata,
  input logic [idpst_pkg::STAT_W-1:0]         out_tuser
);
  import idpst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second operation accepted while one is in flight");

  a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STAT_EMPTY)
      |-> out_tdata[OUT_LIVE_LSB +: LIVE_W] == LIVE_W'(POOL_SIZE))
    else $error("pool empty reported with identifiers still free");

  a_err_no_sig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_OK) |-> out_tdata[OUT_SIG_LSB +: SIG_IO_W] == '0)
    else $error("signature returned on a failed operation");

endmodule

bind id_pool_with_signature_table_core idpst_checker u_idpst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: sim/id_pool_with_signature_table_core_test.sv
// ----------------------------------------------------------------------------
// id_pool_with_signature_table_core_test
// Self-checking bench for the identifier pool with signature table. A driver
// and a monitor run as clocked processes around the core. Each accepted
// operation is applied to a local model of the free ring, live count and
// signature store, and the predicted result is queued. Every result transfer
// is compared field by field with the oldest prediction. Stimulus runs a
// directed opening, mixed random traffic that mostly targets live
// identifiers, and a full drain of the pool with creates on the empty pool.
// Both sides insert random idle gaps.
// ----------------------------------------------------------------------------
module id_pool_with_signature_table_core_test;
  import idpst_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_SHOWN    = 10;
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
  localparam int IDENT_MAX = (1 << IDENT_W) - 1;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [IDENT_W-1:0]  ident;
    logic [SIG_IO_W-1:0] sig;
  } pool_op_t;

  typedef struct {
    logic [IDENT_W-1:0]  ident;
    logic [SIG_IO_W-1:0] sig;
    logic [LIVE_W-1:0]   live;
    logic [STAT_W-1:0]   status;
  } pool_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  // model of the pool
  logic [IDENT_W-1:0]    free_ring [POOL_SIZE];
  logic [SIG_BITS-1:0]   sig_store [POOL_SIZE];
  int unsigned           ring_rd;
  int unsigned           ring_wr;
  int unsigned           live_n;
  logic [IDENT_W-1:0]    live_ids [$];

  pool_op_t              op_backlog [$];
  pool_result_t          due_results [$];
  int unsigned           n_issued = 0;
  int unsigned           n_accepted = 0;
  int unsigned           bad_count = 0;
  bit                    in_done = 1'b0;
  bit                    idle_on = 1'b1;
  int                    send_gap = 0;
  int                    stall_left = 0;

  id_pool_with_signature_table_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void pool_restore();
    for (int i = 0; i < POOL_SIZE; i++) begin
      free_ring[i] = IDENT_W'(i);
      sig_store[i] = '0;
    end
    ring_rd = 0;
    ring_wr = 0;
    live_n  = 0;
    live_ids.delete();
  endfunction

  function automatic int unsigned ring_step(int unsigned slot);
    return (slot + 1 >= POOL_SIZE) ? 0 : slot + 1;
  endfunction

  function automatic void live_drop(logic [IDENT_W-1:0] id);
    for (int i = 0; i < live_ids.size(); i++) begin
      if (live_ids[i] == id) begin
        live_ids.delete(i);
        return;
      end
    end
  endfunction

  function automatic pool_result_t pool_apply(pool_op_t t);
    pool_result_t res;
    bit           in_range;
    in_range   = int'(t.ident) < POOL_SIZE;
    res.ident  = t.ident;
    res.sig    = '0;
    res.status = STAT_OK;
    case (t.op)
      OP_CREATE: begin
        if (live_n >= POOL_SIZE) begin
          res.status = STAT_EMPTY;
        end else begin
          res.ident = free_ring[ring_rd];
          ring_rd   = ring_step(ring_rd);
          live_n++;
          live_ids.push_back(res.ident);
        end
      end
      OP_DESTROY: begin
        if (!in_range) begin
          res.status = STAT_RANGE;
        end else if (live_n > 0) begin
          sig_store[t.ident] = '0;
          free_ring[ring_wr] = t.ident;
          ring_wr = ring_step(ring_wr);
          live_n--;
          live_drop(t.ident);
        end
      end
      OP_GET: begin
        if (!in_range) res.status = STAT_RANGE;
        else res.sig = SIG_IO_W'(sig_store[t.ident]);
      end
      OP_SET: begin
        if (!in_range) res.status = STAT_RANGE;
        else sig_store[t.ident] = t.sig[SIG_BITS-1:0];
      end
      OP_DESTROY_ALL: begin
        pool_restore();
      end
      default: begin
      end
    endcase
    res.live = LIVE_W'(live_n);
    return res;
  endfunction

  // driver: present the next operation at the falling edge
  always @(negedge clk) begin
    pool_op_t nxt;
    if (rst_n && (!in_tvalid || in_done)) begin
      in_done = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        nxt = op_backlog.pop_front();
        in_tdata  <= {{(IN_DATA_W - IDENT_W - SIG_IO_W){1'b0}}, nxt.sig, nxt.ident};
        in_tuser  <= nxt.op;
        in_tvalid <= 1'b1;
        send_gap = idle_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = idle_len();
    end
  end

  // monitor: check results, then model accepted operations
  always @(posedge clk) begin
    pool_op_t     t;
    pool_result_t want;
    pool_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.ident  = out_tdata[IDENT_W-1:0];
        got.sig    = out_tdata[OUT_SIG_LSB +: SIG_IO_W];
        got.live   = out_tdata[OUT_LIVE_LSB +: LIVE_W];
        got.status = out_tuser;
        if (due_results.size() == 0) begin
          if (bad_count < MAX_SHOWN)
            $display("unexpected result: ident %0d sig %h live %0d status %0d",
                     got.ident, got.sig, got.live, got.status);
          bad_count++;
        end else begin
          want = due_results.pop_front();
          if (got.ident !== want.ident || got.sig !== want.sig ||
              got.live !== want.live || got.status !== want.status) begin
            if (bad_count < MAX_SHOWN)
              $display("mismatch: exp ident %0d sig %h live %0d status %0d, %s",
                       want.ident, want.sig, want.live, want.status,
                       $sformatf("got ident %0d sig %h live %0d status %0d",
                                 got.ident, got.sig, got.live, got.status));
            bad_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        t.op    = in_tuser;
        t.ident = in_tdata[IDENT_W-1:0];
        t.sig   = in_tdata[IDENT_W +: SIG_IO_W];
        due_results.push_back(pool_apply(t));
        n_accepted++;
        in_done = 1'b1;
      end
    end
  end

  task automatic issue(logic [OP_W-1:0] op, logic [IDENT_W-1:0] id,
                       logic [SIG_IO_W-1:0] sig);
    pool_op_t t;
    while (op_backlog.size() >= 2) @(posedge clk);
    t.op    = op;
    t.ident = id;
    t.sig   = sig;
    op_backlog.push_back(t);
    n_issued++;
    if (n_issued % 100 == 0) idle_on = $urandom_range(0, 3) != 0;
  endtask

  task automatic settle();
    while (n_accepted != n_issued || due_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IDENT_W-1:0] pick_ident();
    if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    return IDENT_W'($urandom_range(0, IDENT_MAX));
  endfunction

  function automatic logic [SIG_IO_W-1:0] pick_sig();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic issue_mixed();
    int r;
    r = $urandom_range(0, 99);
    if (r < 32)      issue(OP_CREATE, IDENT_W'($urandom_range(0, IDENT_MAX)), $urandom);
    else if (r < 54) issue(OP_DESTROY, pick_ident(), $urandom);
    else if (r < 74) issue(OP_GET, pick_ident(), $urandom);
    else if (r < 94) issue(OP_SET, pick_ident(), pick_sig());
    else if (r < 96) issue(OP_DESTROY_ALL, IDENT_W'($urandom_range(0, IDENT_MAX)), $urandom);
    else issue(OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
               IDENT_W'($urandom_range(0, IDENT_MAX)), $urandom);
  endtask

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  initial begin
    pool_restore();
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed opening
    issue(OP_GET, '0, '1);
    issue(OP_DESTROY, 10'd5, '0);
    issue(OP_CREATE, 10'd1023, '0);
    issue(OP_CREATE, '0, '1);
    issue(OP_SET, '0, '1);
    issue(OP_SET, 10'd1023, '0);
    issue(OP_SET, 10'd1, 32'ha5a5_5a5a);
    issue(OP_GET, '0, '0);
    issue(OP_GET, 10'd1023, '1);
    issue(OP_GET, 10'd1, '0);
    issue(OP_DESTROY, 10'd1, '1);
    issue(OP_GET, 10'd1, '0);
    issue(OP_DESTROY, 10'd700, 32'h5a5a_a5a5);
    issue(OP_DESTROY, '0, '0);
    issue(OP_UNUSED_FIRST, 10'h2aa, 32'hffff_0000);
    issue(OP_W'(6), 10'h155, 32'h0000_ffff);
    issue(OP_UNUSED_LAST, '1, '1);
    issue(OP_CREATE, '0, '0);
    issue(OP_SET, 10'd2, 32'h8000_0001);
    issue(OP_DESTROY_ALL, '0, '0);
    issue(OP_GET, 10'd2, '0);
    issue(OP_GET, 10'd1023, '0);
    issue(OP_CREATE, '0, '0);

    for (int i = 0; i < 150; i++) issue_mixed();

    // hold until the core is drained, then exhaust the pool
    settle();
    issue(OP_DESTROY_ALL, '0, '0);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(0, 9) == 0) issue(OP_SET, pick_ident(), pick_sig());
      else if ($urandom_range(0, 9) == 0) issue(OP_GET, pick_ident(), '0);
      issue(OP_CREATE, IDENT_W'($urandom_range(0, IDENT_MAX)), $urandom);
    end
    for (int i = 0; i < 3; i++) issue(OP_CREATE, IDENT_W'($urandom_range(0, IDENT_MAX)), '1);
    issue(OP_GET, pick_ident(), '0);
    issue(OP_DESTROY, pick_ident(), '0);
    issue(OP_DESTROY, pick_ident(), '0);
    for (int i = 0; i < 3; i++) issue(OP_CREATE, '0, '0);

    for (int i = 0; i < 100; i++) issue_mixed();

    settle();
    repeat (POOL_SIZE + 64) @(posedge clk);
    if (bad_count == 0 && due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: id_pool_with_signature_table_core.f
src/idpst_pkg.sv
src/idpst_free_ring.sv
src/idpst_sig_table.sv
src/idpst_ctrl.sv
src/id_pool_with_signature_table_core.sv
src/idpst_checker.sv
sim/id_pool_with_signature_table_core_test.sv
